// ===== hdl/fcp_pkg.sv =====
// Shared types and constants for the fixed chunk pool free list.
// No dependencies; the top level, fcp_front and fcp_back import it.
package fcp_pkg;

   localparam int ADDR_WIDTH          = 32;
   localparam int POOL_CHUNKS_DEFAULT = 1024;
   localparam int TOTAL_WIDTH         = 11;
   localparam int LOG2_WIDTH          = 5;
   localparam int MIN_CHUNK_LOG2      = 3;
   localparam int MAX_CHUNK_LOG2      = 16;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int CSR_DATA_WIDTH      = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BASE_ADDRESS    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHUNK_SIZE_LOG2 = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHUNK_TOTAL     = 2'd2;

   typedef enum logic [1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_FREE    = 2'd1,
      ACT_REBUILD = 2'd2,
      ACT_QUERY   = 2'd3
   } fcp_action_type;

   typedef enum logic [2:0] {
      STAT_OK      = 3'd0,
      STAT_EMPTY   = 3'd1,
      STAT_UNINIT  = 3'd2,
      STAT_BOUNDS  = 3'd3,
      STAT_BADFREE = 3'd4
   } fcp_status_type;

   typedef enum logic [2:0] {
      OP_REPLY   = 3'd0,
      OP_ALLOC   = 3'd1,
      OP_FREE    = 3'd2,
      OP_QUERY   = 3'd3,
      OP_REBUILD = 3'd4
   } fcp_op_type;

   typedef struct packed {
      fcp_action_type          action;
      logic [ADDR_WIDTH-1:0]   address;
   } fcp_req_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0]   chunk_address;
      logic [2:0]              status;
      logic                    mapped;
   } fcp_rsp_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0]   base_address;
      logic [LOG2_WIDTH-1:0]   chunk_size_log2;
      logic [TOTAL_WIDTH-1:0]  chunk_total;
   } fcp_cfg_type;

   typedef struct packed {
      fcp_op_type              op;
      fcp_status_type          status;
      logic                    mapped;
   } fcp_cmd_type;

endpackage

// ===== hdl/fixed_chunk_pool_free_list.sv =====
// Fixed chunk pool free list: top level with configuration registers.
// Depends on fcp_pkg, fcp_front, fcp_queue, fcp_back.
//
// Allocator for up to POOL_CHUNKS equal chunks of 2^chunk_size_log2 bytes at
// base_address. Requests (allocate, free, rebuild, query) enter on the req_
// valid/ready channel; each gives exactly one response on the rsp_ channel,
// in order. Configuration must be written on csr_ only while the block is idle; the block does not enforce it.
// The front end classifies a request in its accept cycle and places it in a
// two-entry queue; the back end then runs it. Errors, misaligned queries and
// allocate on an empty list are answered from the idle state; other allocates,
// frees and queries wait for the registered read of the link or free-bit RAM.
// Rebuild writes one RAM row per cycle over all POOL_CHUNKS rows; the front
// end keeps taking requests until the queue fills.
// Reset clears the registers to base 0, exponent 3, total 0, marks the pool
// uninitialized and the list empty; the RAMs hold nothing until a rebuild.
// When rsp_ready is low with a response held, the response register holds,
// the back end stops before its next response, and req_ready drops once the queue is full.
module fixed_chunk_pool_free_list #(
   parameter int POOL_CHUNKS = fcp_pkg::POOL_CHUNKS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  fcp_pkg::fcp_req_type                   req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output fcp_pkg::fcp_rsp_type                   rsp_data,
   input  logic                                   csr_write,
   input  logic [fcp_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [fcp_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import fcp_pkg::*;

   localparam int IDX_W = $clog2(POOL_CHUNKS + 1);
   localparam int CMD_W = $bits(fcp_cmd_type);
   localparam int Q_W   = IDX_W + CMD_W;

   fcp_cfg_type      cfg_ff, cfg_in;
   logic             q_push, q_pop, q_ready, q_valid;
   fcp_cmd_type      front_cmd, back_cmd;
   logic [IDX_W-1:0] front_idx, back_idx;
   logic [Q_W-1:0]   q_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS:    cfg_in.base_address    = csr_wdata[ADDR_WIDTH-1:0];
            CSR_CHUNK_SIZE_LOG2: cfg_in.chunk_size_log2 = csr_wdata[LOG2_WIDTH-1:0];
            CSR_CHUNK_TOTAL:     cfg_in.chunk_total     = csr_wdata[TOTAL_WIDTH-1:0];
            default:             cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_address    <= '0;
         cfg_ff.chunk_size_log2 <= LOG2_WIDTH'(MIN_CHUNK_LOG2);
         cfg_ff.chunk_total     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fcp_front #(.POOL_CHUNKS(POOL_CHUNKS), .IDX_W(IDX_W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_ready   (q_ready),
      .q_push    (q_push),
      .q_cmd     (front_cmd),
      .q_idx     (front_idx)
   );

   fcp_queue #(.WIDTH(Q_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({front_idx, front_cmd}),
      .ready     (q_ready),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_rdata)
   );

   assign back_cmd = fcp_cmd_type'(q_rdata[CMD_W-1:0]);
   assign back_idx = q_rdata[Q_W-1:CMD_W];

   fcp_back #(.POOL_CHUNKS(POOL_CHUNKS), .IDX_W(IDX_W)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_cmd     (back_cmd),
      .q_idx     (back_idx),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_ready && req_valid)
      else $error("queue pushed while full");

   a_address_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.chunk_address != '0) |-> rsp_data.status == STAT_OK)
      else $error("chunk address on a failed response");

   a_mapped_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.mapped |-> rsp_data.status == STAT_OK && !$isunknown(rsp_data.status))
      else $error("mapped set on a failed response");

endmodule

// ===== hdl/fcp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module fcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/fcp_front.sv =====
// Front end: accepts requests, checks geometry and bounds, classifies each item.
// Depends on fcp_pkg.
module fcp_front #(
   parameter int POOL_CHUNKS = fcp_pkg::POOL_CHUNKS_DEFAULT,
   parameter int IDX_W       = $clog2(POOL_CHUNKS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fcp_pkg::fcp_cfg_type cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fcp_pkg::fcp_req_type req_data,
   input  logic                 q_ready,
   output logic                 q_push,
   output fcp_pkg::fcp_cmd_type q_cmd,
   output logic [IDX_W-1:0]     q_idx
);
   import fcp_pkg::*;

   localparam logic [31:0] PoolChunks = 32'(POOL_CHUNKS);

   logic                  init_ff;
   logic                  init_in;
   logic                  geo_ok;
   logic                  below;
   logic                  in_bounds;
   logic                  aligned;
   logic [ADDR_WIDTH-1:0] offset;
   logic [ADDR_WIDTH-1:0] offset_idx;
   logic [ADDR_WIDTH-1:0] align_mask;
   logic [ADDR_WIDTH:0]   span;

   assign geo_ok = (cfg.chunk_size_log2 >= LOG2_WIDTH'(MIN_CHUNK_LOG2))
                && (cfg.chunk_size_log2 <= LOG2_WIDTH'(MAX_CHUNK_LOG2))
                && (cfg.chunk_total != '0)
                && (32'(cfg.chunk_total) <= PoolChunks);

   assign below      = req_data.address < cfg.base_address;
   assign offset     = req_data.address - cfg.base_address;
   assign span       = (ADDR_WIDTH + 1)'(cfg.chunk_total) << cfg.chunk_size_log2;
   assign in_bounds  = !below && ({1'b0, offset} < span);
   assign offset_idx = offset >> cfg.chunk_size_log2;
   assign align_mask = ~({ADDR_WIDTH{1'b1}} << cfg.chunk_size_log2);
   assign aligned    = (offset & align_mask) == '0;

   assign req_ready = q_ready;
   assign q_push    = req_valid && q_ready;
   assign q_idx     = offset_idx[IDX_W-1:0];

   always_comb begin
      q_cmd.op     = OP_REPLY;
      q_cmd.status = STAT_OK;
      q_cmd.mapped = 1'b0;
      priority if (!geo_ok) begin
         q_cmd.status = STAT_UNINIT;
      end else if (req_data.action == ACT_REBUILD) begin
         q_cmd.op = OP_REBUILD;
      end else if (!init_ff) begin
         q_cmd.status = STAT_UNINIT;
      end else if (req_data.action == ACT_ALLOC) begin
         q_cmd.op = OP_ALLOC;
      end else if (!in_bounds) begin
         q_cmd.status = STAT_BOUNDS;
      end else if (req_data.action == ACT_FREE) begin
         if (aligned) begin
            q_cmd.op = OP_FREE;
         end else begin
            q_cmd.status = STAT_BADFREE;
         end
      end else begin
         if (aligned) begin
            q_cmd.op = OP_QUERY;
         end else begin
            q_cmd.mapped = 1'b1;
         end
      end
   end

   assign init_in = init_ff
                 || (q_push && geo_ok && (req_data.action == ACT_REBUILD));

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= 1'b0;
      end else begin
         init_ff <= init_in;
      end
   end

endmodule

// ===== hdl/fcp_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on nothing.
module fcp_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             ready,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_in;
   logic [1:0]       count_in;

   assign ready    = count_ff != 2'd2;
   assign valid    = count_ff != 2'd0;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/fcp_back.sv =====
// Back end: runs queued commands against the head register, the link RAM and
// the free-bit RAM, and holds the response register. Depends on fcp_pkg, fcp_ram.
module fcp_back #(
   parameter int POOL_CHUNKS = fcp_pkg::POOL_CHUNKS_DEFAULT,
   parameter int IDX_W       = $clog2(POOL_CHUNKS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fcp_pkg::fcp_cfg_type cfg,
   input  logic                 q_valid,
   input  fcp_pkg::fcp_cmd_type q_cmd,
   input  logic [IDX_W-1:0]     q_idx,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fcp_pkg::fcp_rsp_type rsp_data
);
   import fcp_pkg::*;

   localparam int              AW       = (POOL_CHUNKS > 1) ? $clog2(POOL_CHUNKS) : 1;
   localparam logic [IDX_W-1:0] NullIdx = IDX_W'(POOL_CHUNKS);
   localparam logic [IDX_W-1:0] LastIdx = IDX_W'(POOL_CHUNKS - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WAIT,
      S_SWEEP
   } state_type;

   state_type        state_ff, state_in;
   fcp_op_type       op_ff, op_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   fcp_rsp_type      rsp_data_ff, rsp_data_in;

   logic             out_free;
   logic             emit;
   fcp_rsp_type      emit_data;
   logic [ADDR_WIDTH-1:0] alloc_address;
   logic [IDX_W-1:0] cnt_next;

   logic             link_wr_en, link_rd_en;
   logic [AW-1:0]    link_wr_addr, link_rd_addr;
   logic [IDX_W-1:0] link_wr_data, link_rd_data;
   logic             free_wr_en, free_rd_en;
   logic [AW-1:0]    free_wr_addr, free_rd_addr;
   logic             free_wr_data, free_rd_data;

   fcp_ram #(.WIDTH(IDX_W), .DEPTH(POOL_CHUNKS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data)
   );

   fcp_ram #(.WIDTH(1), .DEPTH(POOL_CHUNKS)) u_free_ram (
      .clock   (clock),
      .wr_en   (free_wr_en),
      .wr_addr (free_wr_addr),
      .wr_data (free_wr_data),
      .rd_en   (free_rd_en),
      .rd_addr (free_rd_addr),
      .rd_data (free_rd_data)
   );

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign alloc_address = cfg.base_address + (ADDR_WIDTH'(head_ff) << cfg.chunk_size_log2);
   assign cnt_next      = cnt_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      q_pop        = 1'b0;
      emit         = 1'b0;
      emit_data    = '0;
      link_wr_en   = 1'b0;
      link_wr_addr = head_ff[AW-1:0];
      link_wr_data = head_ff;
      link_rd_en   = 1'b0;
      link_rd_addr = head_ff[AW-1:0];
      free_wr_en   = 1'b0;
      free_wr_addr = head_ff[AW-1:0];
      free_wr_data = 1'b0;
      free_rd_en   = 1'b0;
      free_rd_addr = q_idx[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop  = 1'b1;
               op_in  = q_cmd.op;
               idx_in = q_idx;
               unique case (q_cmd.op)
                  OP_REPLY: begin
                     emit             = 1'b1;
                     emit_data.status = q_cmd.status;
                     emit_data.mapped = q_cmd.mapped;
                  end
                  OP_ALLOC: begin
                     if (head_ff == NullIdx) begin
                        emit             = 1'b1;
                        emit_data.status = STAT_EMPTY;
                     end else begin
                        link_rd_en = 1'b1;
                        free_wr_en = 1'b1;
                        state_in   = S_WAIT;
                     end
                  end
                  OP_FREE, OP_QUERY: begin
                     free_rd_en = 1'b1;
                     state_in   = S_WAIT;
                  end
                  OP_REBUILD: begin
                     cnt_in   = '0;
                     state_in = S_SWEEP;
                  end
                  default: begin
                     emit             = 1'b1;
                     emit_data.status = STAT_UNINIT;
                  end
               endcase
            end
         end
         S_WAIT: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               unique case (op_ff)
                  OP_ALLOC: begin
                     head_in                 = link_rd_data;
                     emit_data.chunk_address = alloc_address;
                  end
                  OP_FREE: begin
                     if (free_rd_data) begin
                        emit_data.status = STAT_BADFREE;
                     end else begin
                        link_wr_en   = 1'b1;
                        link_wr_addr = idx_ff[AW-1:0];
                        link_wr_data = head_ff;
                        free_wr_en   = 1'b1;
                        free_wr_addr = idx_ff[AW-1:0];
                        free_wr_data = 1'b1;
                        head_in      = idx_ff;
                     end
                  end
                  OP_QUERY: begin
                     emit_data.mapped = !free_rd_data;
                  end
                  default: begin
                     emit_data.status = STAT_UNINIT;
                  end
               endcase
            end
         end
         S_SWEEP: begin
            link_wr_en   = 1'b1;
            link_wr_addr = cnt_ff[AW-1:0];
            link_wr_data = (32'(cnt_next) < 32'(cfg.chunk_total)) ? cnt_next : NullIdx;
            free_wr_en   = 1'b1;
            free_wr_addr = cnt_ff[AW-1:0];
            free_wr_data = 32'(cnt_ff) < 32'(cfg.chunk_total);
            if (cnt_ff == LastIdx) begin
               if (out_free) begin
                  emit     = 1'b1;
                  head_in  = '0;
                  state_in = S_IDLE;
               end
            end else begin
               cnt_in = cnt_next;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NullIdx;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
